### rtl/kedf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kedf_pkg: shared types and constants of the key event decoder FIFO
// Request layouts, configuration register set, decode actions and codes.
// ----------------------------------------------------------------------------
package kedf_pkg;

    // Input request: key event or pop
    typedef struct packed {
        logic       func;
        logic [1:0] event_kind;
        logic [7:0] scan_code;
    } t_in_item;

    // Result request
    typedef struct packed {
        logic       char_valid;
        logic [7:0] char_out;
        logic       not_empty;
        logic [4:0] fill_level;
        logic       break_seen;
        logic       overflow;
    } t_out_item;

    // Configuration register set
    typedef struct packed {
        logic [7:0] ctrl_code;
        logic [7:0] shift_left_code;
        logic [7:0] shift_right_code;
        logic [7:0] alt_code;
        logic [7:0] break_code;
        logic [7:0] caps_code;
        logic [7:0] enter_code;
        logic [7:0] return_code;
    } t_cfg_regs;

    // Decoded action of one request
    typedef struct packed {
        logic       pop_req;
        logic       push;
        logic [7:0] push_char;
        logic       brk;
        logic       ovf;
        logic       ctrl_set;
        logic       ctrl_clr;
        logic       shift_set;
        logic       shift_clr;
    } t_key_action;

    // Partial result held while the character store read completes
    typedef struct packed {
        logic char_valid;
        logic break_seen;
        logic overflow;
    } t_stage_a;

    // Configuration register indexes
    localparam logic [7:0] CFG_CTRL        = 8'd0;
    localparam logic [7:0] CFG_SHIFT_LEFT  = 8'd1;
    localparam logic [7:0] CFG_SHIFT_RIGHT = 8'd2;
    localparam logic [7:0] CFG_ALT         = 8'd3;
    localparam logic [7:0] CFG_BREAK       = 8'd4;
    localparam logic [7:0] CFG_CAPS        = 8'd5;
    localparam logic [7:0] CFG_ENTER       = 8'd6;
    localparam logic [7:0] CFG_RETURN      = 8'd7;

    // Register reset values
    localparam t_cfg_regs CFG_RESET = '{
        ctrl_code:        8'd165,
        shift_left_code:  8'd162,
        shift_right_code: 8'd163,
        alt_code:         8'd161,
        break_code:       8'd208,
        caps_code:        8'd193,
        enter_code:       8'd10,
        return_code:      8'd13
    };

    // Request codes
    localparam logic       FUNC_KEY   = 1'b0;
    localparam logic       FUNC_POP   = 1'b1;
    localparam logic [1:0] EV_IDLE    = 2'd0;
    localparam logic [1:0] EV_PRESS   = 2'd1;
    localparam logic [1:0] EV_HELD    = 2'd2;
    localparam logic [1:0] EV_RELEASE = 2'd3;

    // Character conversion constants
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CTRL_MASK    = 8'h1F;
    localparam logic [7:0] CASE_BIT     = 8'h20;

    // Result queue depth
    localparam int unsigned OQ_DEPTH = 3;

endpackage
`default_nettype wire

### rtl/kedf_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kedf_decode: key event decoder
// Turns one request into modifier updates, a FIFO push or pop, and pulses.
// ----------------------------------------------------------------------------
module kedf_decode
    import kedf_pkg::*;
(
    input  var t_in_item    i_item,
    input  var t_cfg_regs   i_cfg,
    input  wire             i_ctrl_held,
    input  wire             i_shift_held,
    input  wire             i_full,
    output t_key_action     o_act
);

    function automatic logic [7:0] convert_key(
        input logic [7:0] ch,
        input logic       ctrl,
        input logic       shift,
        input t_cfg_regs  cfg
    );
        logic [7:0] res;
        res = ch;
        if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
            if (ctrl) begin
                res = res & CTRL_MASK;
            end
            if (shift) begin
                res = res & ~CASE_BIT;
            end
        end else if (ch == cfg.enter_code) begin
            res = cfg.return_code;
        end
        return res;
    endfunction

    logic is_ctrl;
    logic is_shift;

    assign is_ctrl  = (i_item.scan_code == i_cfg.ctrl_code);
    assign is_shift = (i_item.scan_code == i_cfg.shift_left_code) ||
                      (i_item.scan_code == i_cfg.shift_right_code);

    always_comb begin
        o_act = '0;
        if (i_item.func == FUNC_POP) begin
            o_act.pop_req = 1'b1;
        end else begin
            case (i_item.event_kind)
                EV_PRESS: begin
                    if (is_ctrl) begin
                        o_act.ctrl_set = 1'b1;
                    end else if (is_shift) begin
                        o_act.shift_set = 1'b1;
                    end else if (i_item.scan_code == i_cfg.alt_code) begin
                        // swallow
                    end else if (i_item.scan_code == i_cfg.break_code) begin
                        o_act.brk = 1'b1;
                    end else if (i_item.scan_code == i_cfg.caps_code) begin
                        // swallow
                    end else if (i_full) begin
                        o_act.ovf = 1'b1;
                    end else begin
                        o_act.push      = 1'b1;
                        o_act.push_char = convert_key(i_item.scan_code, i_ctrl_held,
                                                      i_shift_held, i_cfg);
                    end
                end
                EV_RELEASE: begin
                    if (is_ctrl) begin
                        o_act.ctrl_clr = 1'b1;
                    end else if (is_shift) begin
                        o_act.shift_clr = 1'b1;
                    end
                end
                default: begin
                    // idle and held events do nothing
                end
            endcase
        end
    end

endmodule
`default_nettype wire

### rtl/kedf_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kedf_fifo: character store
// Circular buffer with fill count and a registered read port.
// ----------------------------------------------------------------------------
module kedf_fifo #(
    parameter int unsigned DEPTH = 16
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_push,
    input  wire  [7:0]                      i_wr_data,
    input  wire                             i_pop,
    output logic [7:0]                      o_rd_data,
    output logic [$clog2(DEPTH+1)-1:0]      o_count,
    output logic                            o_full,
    output logic                            o_empty
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [7:0]       r_mem [DEPTH];
    logic [7:0]       r_rd_data;
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    // Store write and registered read
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
        if (i_pop) begin
            r_rd_data <= r_mem[r_rd_ptr];
        end
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_count   = r_count;
    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);

endmodule
`default_nettype wire

### rtl/kedf_outq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kedf_outq: result queue
// Small register queue that decouples result delivery from request intake.
// ----------------------------------------------------------------------------
module kedf_outq
    import kedf_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_push,
    input  var t_out_item i_item,
    input  wire         i_pop,
    output t_out_item   o_item,
    output logic        o_valid,
    output logic [1:0]  o_count
);

    logic [1:0] r_wr_ptr, n_wr_ptr;
    logic [1:0] r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    t_out_item  r_entry [OQ_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_item;
        end
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == 2'(OQ_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == 2'(OQ_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    assign o_item  = r_entry[r_rd_ptr];
    assign o_valid = (r_count != '0);
    assign o_count = r_count;

endmodule
`default_nettype wire

### rtl/key_event_decoder_fifo_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// key_event_decoder_fifo_core: keyboard event decoder with character FIFO
// Tracks Ctrl and Shift, converts pressed keys into characters and queues
// them; pop requests return the oldest character.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                Payload              Direction
//  --------  -----------------------  -------------------  ---------
//  input     i_in_valid / o_in_stall  i_in_data  (t_in_item)   in
//  result    o_out_valid / i_out_stall o_out_data (t_out_item) out
//  config    i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data in
//
//  One request is taken every cycle while o_in_stall is low; its pulses are
//  held in r_a while the registered read of the character store completes,
//  and the result is then written into the result queue that presents it.
//  A three-entry result queue absorbs output stalls; o_in_stall rises only
//  when the queued results plus the request in flight fill its three entries.
//  Synchronous active-low reset clears modifiers, pointers, counts and
//  configuration (to the default key codes); the store contents are not
//  cleared. Configuration writes are always ready.
//
module key_event_decoder_fifo_core
    import kedf_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input request channel
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  var t_in_item i_in_data,
    // result channel
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output t_out_item   o_out_data,
    // configuration write channel
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [7:0]  i_cfg_index,
    input  wire  [7:0]  i_cfg_data
);

    localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

    t_cfg_regs   r_cfg;
    logic        r_ctrl_held, n_ctrl_held;
    logic        r_shift_held, n_shift_held;
    logic        r_a_valid;
    t_stage_a    r_a;

    t_key_action act;
    logic        in_acc;
    logic        pop_ok;
    logic [7:0]  rd_data;
    logic [CNT_W-1:0] fifo_count;
    logic        fifo_full;
    logic        fifo_empty;
    t_out_item   res_item;
    logic [1:0]  oq_count;
    logic [2:0]  occupancy;

    // Configuration registers: ignore indexes beyond the list
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_CTRL:        r_cfg.ctrl_code        <= i_cfg_data;
                CFG_SHIFT_LEFT:  r_cfg.shift_left_code  <= i_cfg_data;
                CFG_SHIFT_RIGHT: r_cfg.shift_right_code <= i_cfg_data;
                CFG_ALT:         r_cfg.alt_code         <= i_cfg_data;
                CFG_BREAK:       r_cfg.break_code       <= i_cfg_data;
                CFG_CAPS:        r_cfg.caps_code        <= i_cfg_data;
                CFG_ENTER:       r_cfg.enter_code       <= i_cfg_data;
                CFG_RETURN:      r_cfg.return_code      <= i_cfg_data;
                default: begin
                    // drop writes to unknown registers
                end
            endcase
        end
    end

    // Hold off intake only when the queue could not take the results
    // already committed plus one more.
    assign occupancy  = {1'b0, oq_count} + {2'b00, r_a_valid};
    assign o_in_stall = (occupancy >= 3'(OQ_DEPTH));
    assign in_acc     = i_in_valid && !o_in_stall;

    // Decode the request against current modifier and fill state
    kedf_decode u_decode (
        .i_item       (i_in_data),
        .i_cfg        (r_cfg),
        .i_ctrl_held  (r_ctrl_held),
        .i_shift_held (r_shift_held),
        .i_full       (fifo_full),
        .o_act        (act)
    );

    // Pop only when a character is there
    assign pop_ok = in_acc && act.pop_req && !fifo_empty;

    kedf_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (in_acc && act.push),
        .i_wr_data (act.push_char),
        .i_pop     (pop_ok),
        .o_rd_data (rd_data),
        .o_count   (fifo_count),
        .o_full    (fifo_full),
        .o_empty   (fifo_empty)
    );

    // Modifier tracking
    always_comb begin
        n_ctrl_held  = r_ctrl_held;
        n_shift_held = r_shift_held;
        if (in_acc) begin
            if (act.ctrl_set) begin
                n_ctrl_held = 1'b1;
            end else if (act.ctrl_clr) begin
                n_ctrl_held = 1'b0;
            end
            if (act.shift_set) begin
                n_shift_held = 1'b1;
            end else if (act.shift_clr) begin
                n_shift_held = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_held  <= 1'b0;
            r_shift_held <= 1'b0;
            r_a_valid    <= 1'b0;
        end else begin
            r_ctrl_held  <= n_ctrl_held;
            r_shift_held <= n_shift_held;
            r_a_valid    <= in_acc;
        end
    end

    // Hold the pulses and the pop outcome while the store read lands
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a.char_valid <= pop_ok;
            r_a.break_seen <= act.brk;
            r_a.overflow   <= act.ovf;
        end
    end

    // Assemble the result: the fill count now reflects this request alone,
    // since any later request has not reached an edge yet.
    always_comb begin
        res_item.char_valid = r_a.char_valid;
        res_item.char_out   = r_a.char_valid ? rd_data : 8'h00;
        res_item.not_empty  = !fifo_empty;
        res_item.fill_level = 5'(fifo_count);
        res_item.break_seen = r_a.break_seen;
        res_item.overflow   = r_a.overflow;
    end

    kedf_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_a_valid),
        .i_item  (res_item),
        .i_pop   (o_out_valid && !i_out_stall),
        .o_item  (o_out_data),
        .o_valid (o_out_valid),
        .o_count (oq_count)
    );

endmodule
`default_nettype wire

### rtl/kedf_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kedf_checker: port-level checks for the key event decoder FIFO
// Watches the result channel for consistency and handshake behaviour.
// ----------------------------------------------------------------------------
module kedf_checker
    import kedf_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         o_out_valid,
    input  wire         i_out_stall,
    input  var t_out_item o_out_data
);

    // A character is shown only when a pop returned one
    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.char_valid |-> o_out_data.char_out == 8'h00)
        else $error("char_out not zero without char_valid");

    // A non-zero fill level means the store holds something
    a_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.fill_level != 5'd0) |-> o_out_data.not_empty)
        else $error("not_empty disagrees with fill_level");

    // One request raises at most one of the outcomes
    a_one_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $countones({o_out_data.char_valid, o_out_data.break_seen,
                                    o_out_data.overflow}) <= 1)
        else $error("several outcomes in one result");

    // A stalled result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

endmodule

bind key_event_decoder_fifo_core kedf_checker u_kedf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
`default_nettype wire
